### rtl/core/aesck_pkg.sv
// Shared types, constants and round functions for the AES-128 counter keystream block.
// No dependencies; imported by the round cell and the top level.
`timescale 1ns / 1ps
`default_nettype none
package aesck_pkg;

  localparam int unsigned NumRounds = 10;
  localparam logic [63:0] BlockTag  = 64'h0123456789ABCDEF;
  localparam logic [4:0]  MaxBytes  = 5'd16;

  // configuration register offsets (byte address bit 3)
  localparam logic RegKeyLow  = 1'b0;
  localparam logic RegKeyHigh = 1'b1;

  localparam logic [7:0] RCON [NumRounds] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1B, 8'h36
  };

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // one pipeline beat: state byte i sits in bits 8i+7:8i
  typedef struct packed {
    logic [4:0]   cnt;
    logic [127:0] rkey;
    logic [127:0] blk;
  } stage_t;

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
  endfunction

  // SubBytes followed by ShiftRows
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[8*(i+4*c) +: 8] = SBOX[s[8*(i+4*((c+i)%4)) +: 8]];
      end
    end
    sub_shift = t;
  endfunction

  function automatic logic [127:0] mix_cols(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0]   a0, a1, a2, a3, all;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0  = s[32*c +: 8];
      a1  = s[32*c+8 +: 8];
      a2  = s[32*c+16 +: 8];
      a3  = s[32*c+24 +: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      t[32*c +: 8]    = a0 ^ all ^ xtime(a0 ^ a1);
      t[32*c+8 +: 8]  = a1 ^ all ^ xtime(a1 ^ a2);
      t[32*c+16 +: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[32*c+24 +: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    mix_cols = t;
  endfunction

  // one step of the key schedule: four words in, next four words out
  function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w3, t, n0, n1, n2, n3;
    w3 = k[127:96];
    t  = {SBOX[w3[7:0]], SBOX[w3[31:24]], SBOX[w3[23:16]], SBOX[w3[15:8]] ^ rc};
    n0 = k[31:0] ^ t;
    n1 = k[63:32] ^ n0;
    n2 = k[95:64] ^ n1;
    n3 = w3 ^ n2;
    key_step = {n3, n2, n1, n0};
  endfunction

endpackage
`default_nettype wire

### rtl/core/aesck_req_if.sv
// Request channel: valid/ready handshake carrying the wanted byte count.
// Depends on nothing; it does not import the package.
`timescale 1ns / 1ps
`default_nettype none
interface aesck_req_if;
  logic       valid;
  logic       ready;
  logic [4:0] byte_count;

  modport source (output valid, output byte_count, input ready);
  modport sink   (input valid, input byte_count, output ready);
endinterface
`default_nettype wire

### rtl/core/aesck_ks_if.sv
// Keystream channel: valid/ready handshake carrying 16 keystream bytes and a byte count.
// Depends on nothing; it does not import the package.
`timescale 1ns / 1ps
`default_nettype none
interface aesck_ks_if;
  logic        valid;
  logic        ready;
  logic [63:0] stream_low;
  logic [63:0] stream_high;
  logic [4:0]  valid_bytes;

  modport source (output valid, output stream_low, output stream_high,
                  output valid_bytes, input ready);
  modport sink   (input valid, input stream_low, input stream_high,
                  input valid_bytes, output ready);
endinterface
`default_nettype wire

### rtl/core/aesck_round_cell.sv
// One AES round cell: expands its round key and applies one round, registering the beat.
// Depends on aesck_pkg.
`timescale 1ns / 1ps
`default_nettype none
module aesck_round_cell
  import aesck_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       adv,
  input  wire logic [7:0] rcon,
  input  wire logic       last_round,
  input  wire logic       prev_v,
  input  wire stage_t     prev_d,
  output logic            v_r,
  output stage_t          d_r
);

  stage_t       d_nxt;
  logic [127:0] sub_s;
  logic [127:0] key_n;

  always_comb begin
    key_n       = key_step(prev_d.rkey, rcon);
    sub_s       = sub_shift(prev_d.blk);
    d_nxt.cnt   = prev_d.cnt;
    d_nxt.rkey  = key_n;
    d_nxt.blk   = (last_round ? sub_s : mix_cols(sub_s)) ^ key_n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= prev_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && prev_v) begin
      d_r <= d_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/core/aes128_counter_keystream.sv
// AES-128 counter-mode keystream generator: a chain of ten round cells behind a key-add stage.
// Depends on aesck_pkg, aesck_req_if, aesck_ks_if and aesck_round_cell.
//
// Usage:
//   in_req   : one beat per block, byte_count 1..16 (above 16 saturates to 16). A beat with
//              byte_count zero is taken and dropped: no block, counter unchanged.
//   out_ks   : 16 keystream bytes (byte 0 in stream_low[7:0]) plus valid_bytes.
//   APB port : key_low at 0x0, key_high at 0x8, 64-bit data, pready tied high.
//              Write the key only while no block is in flight.
// Pipeline: the key-add stage loads at the accepting edge, then ten round cells, each one
//           register, carry the block to out_ks.valid.
// Throughput: one block per cycle while out_ks does not stall; a cell hands its beat on when it advances.
// Stall   : each cell advances while it is empty or its successor advances, so bubbles
//           squeeze out; with out_ks stalled the chain fills and in_req.ready drops after
//           eleven beats.
// Reset   : clears all cell valid bits, the block counter and both key registers.
`timescale 1ns / 1ps
`default_nettype none
module aes128_counter_keystream
  import aesck_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  aesck_req_if.sink        in_req,
  aesck_ks_if.source       out_ks,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  logic [63:0] key_low_r, key_high_r;
  logic [63:0] ctr_r, ctr_nxt;
  logic        cfg_wr;
  logic        in_take;
  logic        blk_take;
  logic [4:0]  cnt_sat;

  logic              v   [NumRounds+1];
  stage_t            d   [NumRounds+1];
  logic              adv [NumRounds+1];
  stage_t            d0_nxt;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
    end else if (cfg_wr) begin
      if (paddr[3] == RegKeyHigh) begin
        key_high_r <= pwdata;
      end else begin
        key_low_r  <= pwdata;
      end
    end
  end

  always_comb begin
    if (paddr[2:0] != 3'd0) begin
      prdata = '0;
    end else if (paddr[3] == RegKeyLow) begin
      prdata = key_low_r;
    end else begin
      prdata = key_high_r;
    end
  end

  // advance chain, from the output side back
  assign adv[NumRounds] = !v[NumRounds] || out_ks.ready;
  generate
    for (genvar g = 0; g < NumRounds; g++) begin : g_adv
      assign adv[g] = !v[g] || adv[g+1];
    end
  endgenerate

  assign in_req.ready = adv[0];
  assign in_take      = in_req.valid && in_req.ready;
  assign blk_take     = in_take && (in_req.byte_count != 5'd0);
  assign cnt_sat      = (in_req.byte_count > MaxBytes) ? MaxBytes : in_req.byte_count;
  assign ctr_nxt      = ctr_r + 64'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r <= '0;
    end else if (blk_take) begin
      ctr_r <= ctr_nxt;
    end
  end

  // key-add stage
  always_comb begin
    d0_nxt.cnt  = cnt_sat;
    d0_nxt.rkey = {key_high_r, key_low_r};
    d0_nxt.blk  = {BlockTag, ctr_r} ^ {key_high_r, key_low_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v[0] <= 1'b0;
    end else if (adv[0]) begin
      v[0] <= blk_take;
    end
  end

  always_ff @(posedge clk) begin
    if (blk_take) begin
      d[0] <= d0_nxt;
    end
  end

  generate
    for (genvar r = 1; r <= NumRounds; r++) begin : g_round
      aesck_round_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv[r]),
        .rcon       (RCON[r-1]),
        .last_round (r == NumRounds),
        .prev_v     (v[r-1]),
        .prev_d     (d[r-1]),
        .v_r        (v[r]),
        .d_r        (d[r])
      );
    end
  endgenerate

  assign out_ks.valid       = v[NumRounds];
  assign out_ks.stream_low  = d[NumRounds].blk[63:0];
  assign out_ks.stream_high = d[NumRounds].blk[127:64];
  assign out_ks.valid_bytes = d[NumRounds].cnt;

  // a delivered block always carries between one and sixteen bytes
  a_bytes_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ks.valid |-> (out_ks.valid_bytes != 5'd0 && out_ks.valid_bytes <= MaxBytes))
    else $error("valid_bytes out of range");

  // the counter moves exactly when a non-empty request is taken
  a_ctr_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (ctr_r == ($past(blk_take) ? $past(ctr_r) + 64'd1 : $past(ctr_r))))
    else $error("block counter moved without a block");

  // with the key-add and last stages empty, a request is never refused
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (!v[0] && !v[NumRounds]) |-> in_req.ready)
    else $error("request refused with free entry stage");

endmodule
`default_nettype wire
